// ===== rtl/json_token_structure_parser_macros.svh =====
`ifndef JSON_TOKEN_STRUCTURE_PARSER_MACROS_SVH
`define JSON_TOKEN_STRUCTURE_PARSER_MACROS_SVH

// Check that a condition implies another one in the same cycle.
`define JTSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one in the following cycle.
`define JTSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jtsp_pkg.sv =====
`default_nettype none

package jtsp_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DEPTH_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_DEPTH_LIMIT = '0;
  localparam logic [5:0] DEPTH_LIMIT_RST = 6'd32;

  // Token kinds
  localparam logic [3:0] TK_OBJ_OPEN  = 4'd0;
  localparam logic [3:0] TK_OBJ_CLOSE = 4'd1;
  localparam logic [3:0] TK_ARR_OPEN  = 4'd2;
  localparam logic [3:0] TK_ARR_CLOSE = 4'd3;
  localparam logic [3:0] TK_STRING    = 4'd4;
  localparam logic [3:0] TK_NUMBER    = 4'd5;
  localparam logic [3:0] TK_BOOL      = 4'd6;
  localparam logic [3:0] TK_NULL      = 4'd7;
  localparam logic [3:0] TK_COLON     = 4'd8;
  localparam logic [3:0] TK_COMMA     = 4'd9;

  // Event kinds
  localparam logic [3:0] EV_OBJ_ENTER = 4'd0;
  localparam logic [3:0] EV_OBJ_LEAVE = 4'd1;
  localparam logic [3:0] EV_ARR_ENTER = 4'd2;
  localparam logic [3:0] EV_ARR_LEAVE = 4'd3;
  localparam logic [3:0] EV_KEY       = 4'd4;
  localparam logic [3:0] EV_STRING    = 4'd5;
  localparam logic [3:0] EV_NUMBER    = 4'd6;
  localparam logic [3:0] EV_BOOL      = 4'd7;
  localparam logic [3:0] EV_NULL      = 4'd8;
  localparam logic [3:0] EV_ERROR     = 4'd9;

  // Grammar phase
  typedef enum logic [6:0] {
    PH_TOP      = 7'b0000001,
    PH_OBJ_KEY  = 7'b0000010,
    PH_COLON    = 7'b0000100,
    PH_VALUE    = 7'b0001000,
    PH_ARR_ELEM = 7'b0010000,
    PH_AFTER    = 7'b0100000,
    PH_DONE     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  depth;
    logic [15:0] count;
    logic        bool_value;
    logic [31:0] text_ref;
    logic        done;
  } event_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic push_obj;
    logic pop;
    logic incr;
  } stack_op_t;

  typedef struct packed {
    logic   emit;
    event_t evt;
    phase_t phase_next;
    logic   err_next;
  } decision_t;

endpackage

`default_nettype wire

// ===== rtl/jtsp_token_if.sv =====
`default_nettype none

interface jtsp_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic        bool_true;
  logic [31:0] token_ref;
  logic        doc_start;

  modport source (output valid, token_kind, bool_true, token_ref, doc_start, input ready);
  modport sink (input valid, token_kind, bool_true, token_ref, doc_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/jtsp_event_if.sv =====
`default_nettype none

interface jtsp_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [5:0]  event_depth;
  logic [15:0] member_count;
  logic        bool_value;
  logic [31:0] text_ref;
  logic        document_done;

  modport source (output valid, event_kind, event_depth, member_count, bool_value, text_ref,
                  document_done, input ready);
  modport sink (input valid, event_kind, event_depth, member_count, bool_value, text_ref,
                document_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/json_token_structure_parser.sv =====
// JSON structure parser.
// Channel tok takes one lexed token per item (kind, boolean flag, text reference,
// document start); channel evt delivers at most one structural event per token:
// enter, leave with member count, key, scalar, or error. Expected colon and comma
// tokens, and later tokens of a failed or finished document, give no event.
// The APB port holds depth_limit at address 0; write it only while the block is idle.
// Timing: an accepted token sits in the input register, is decoded against the
// phase and the container stack, and its event is registered in the result
// register by the same decode. One token per cycle is sustained while evt is not
// stalled; the stack keeps its top two entries in registers, so a push or
// pop plus the parent's count update completes in the decode cycle.
// When evt is stalled, the event register holds and the token behind it waits in
// the input register; tok.ready drops only while both are occupied.
// Reset (rst, synchronous) empties both registers, sets the phase to expect a
// top-level value, clears the error and nesting level, and sets depth_limit to 32.
// No clearing pass is needed: a stack entry is used only after being pushed.

`default_nettype none

module json_token_structure_parser import jtsp_pkg::*; #(
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  jtsp_token_if.sink              tok,
  jtsp_event_if.source            evt,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);

  logic [5:0]            depth_limit;

  // Input register
  logic                  in_valid;
  logic [3:0]            in_kind;
  logic                  in_bool;
  logic [31:0]           in_ref;
  logic                  in_doc;

  // Result register
  logic                  out_valid;
  event_t                out_evt;

  // Grammar state
  phase_t                phase;
  logic                  err;

  logic                  adv;
  decision_t             dec;
  stack_op_t             op;
  logic [LVL_W-1:0]      level;
  logic                  top_obj;
  logic [COUNT_BITS-1:0] top_count;

  jtsp_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .depth_limit (depth_limit)
  );

  jtsp_grammar #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COUNT_BITS (COUNT_BITS),
    .LVL_W      (LVL_W)
  ) u_grammar (
    .phase       (phase),
    .err         (err),
    .level       (level),
    .depth_limit (depth_limit),
    .top_obj     (top_obj),
    .top_count   (top_count),
    .token_kind  (in_kind),
    .bool_true   (in_bool),
    .token_ref   (in_ref),
    .doc_start   (in_doc),
    .dec         (dec),
    .op          (op)
  );

  jtsp_stack #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COUNT_BITS (COUNT_BITS),
    .LVL_W      (LVL_W)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .op        (op),
    .level     (level),
    .top_obj   (top_obj),
    .top_count (top_count)
  );

  // Decode the held item once the result register can take its event
  assign adv       = in_valid && (!out_valid || evt.ready);
  assign tok.ready = !in_valid || adv;

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tok.ready) begin
      in_valid <= tok.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok.ready && tok.valid) begin
      in_kind <= tok.token_kind;
      in_bool <= tok.bool_true;
      in_ref  <= tok.token_ref;
      in_doc  <= tok.doc_start;
    end
  end

  // Advance the phase and error flag
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TOP;
      err   <= 1'b0;
    end else if (adv) begin
      phase <= dec.phase_next;
      err   <= dec.err_next;
    end
  end

  // Hold or replace the event
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && dec.emit) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dec.emit) begin
      out_evt <= dec.evt;
    end
  end

  assign evt.valid         = out_valid;
  assign evt.event_kind    = out_evt.kind;
  assign evt.event_depth   = out_evt.depth;
  assign evt.member_count  = out_evt.count;
  assign evt.bool_value    = out_evt.bool_value;
  assign evt.text_ref      = out_evt.text_ref;
  assign evt.document_done = out_evt.done;

endmodule

`default_nettype wire

// ===== rtl/jtsp_apb_regs.sv =====
`default_nettype none

module jtsp_apb_regs import jtsp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output logic      [5:0]         depth_limit
);

  logic sel_limit;

  assign sel_limit = (paddr[PADDR_W-1:2] == REG_DEPTH_LIMIT);
  assign pready    = 1'b1;

  // Write the limit in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= DEPTH_LIMIT_RST;
    end else if (psel && penable && pwrite && sel_limit) begin
      depth_limit <= pwdata[5:0];
    end
  end

  // Read back
  assign prdata = sel_limit ? {26'd0, depth_limit} : 32'd0;

endmodule

`default_nettype wire

// ===== rtl/jtsp_stack.sv =====
`default_nettype none

module jtsp_stack import jtsp_pkg::*; #(
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int LVL_W      = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire stack_op_t             op,
  output logic     [LVL_W-1:0]       level,
  output logic                       top_obj,
  output logic     [COUNT_BITS-1:0]  top_count
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Entries below the cached top pair; entry i belongs to the container at level i
  logic                  kind_mem  [MAX_DEPTH];
  logic [COUNT_BITS-1:0] count_mem [MAX_DEPTH];

  // Entry just below the top, held as registered read data
  logic                  sec_obj;
  logic [COUNT_BITS-1:0] sec_count;

  logic [LVL_W-1:0]      base;
  logic [LVL_W-1:0]      base_m1;
  logic [LVL_W-1:0]      base_m3;
  logic [LVL_W-1:0]      level_next;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] top_inc;
  logic [COUNT_BITS-1:0] sec_inc;

  assign base    = op.clear ? '0 : level;
  assign base_m1 = base - LVL_W'(1);
  assign base_m3 = base - LVL_W'(3);
  assign wr_addr = base_m1[AW-1:0];
  assign rd_addr = base_m3[AW-1:0];

  // Saturating increments
  assign top_inc = (top_count == '1) ? top_count : top_count + 1'b1;
  assign sec_inc = (sec_count == '1) ? sec_count : sec_count + 1'b1;

  always_comb begin
    level_next = base;
    if (op.push) begin
      level_next = base + LVL_W'(1);
    end else if (op.pop) begin
      level_next = base_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (en) begin
      level <= level_next;
    end
  end

  // Push spills the top to memory, pop refills the second entry from it
  always_ff @(posedge clk) begin
    if (en) begin
      if (op.push) begin
        if (base != '0) begin
          kind_mem[wr_addr]  <= top_obj;
          count_mem[wr_addr] <= top_count;
        end
        sec_obj   <= top_obj;
        sec_count <= top_count;
        top_obj   <= op.push_obj;
        top_count <= '0;
      end else if (op.pop) begin
        top_obj   <= sec_obj;
        top_count <= op.incr ? sec_inc : sec_count;
        sec_obj   <= kind_mem[rd_addr];
        sec_count <= count_mem[rd_addr];
      end else if (op.incr) begin
        top_count <= top_inc;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jtsp_grammar.sv =====
`default_nettype none

module jtsp_grammar import jtsp_pkg::*; #(
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int LVL_W      = $clog2(MAX_DEPTH + 1)
) (
  input  wire phase_t                phase,
  input  wire logic                  err,
  input  wire logic [LVL_W-1:0]      level,
  input  wire logic [5:0]            depth_limit,
  input  wire logic                  top_obj,
  input  wire logic [COUNT_BITS-1:0] top_count,
  input  wire logic [3:0]            token_kind,
  input  wire logic                  bool_true,
  input  wire logic [31:0]           token_ref,
  input  wire logic                  doc_start,
  output decision_t                  dec,
  output stack_op_t                  op
);

  localparam int CMP_W = (LVL_W > 6) ? LVL_W : 6;

  phase_t           ph;
  logic             err_e;
  logic [LVL_W-1:0] lvl;
  logic [LVL_W-1:0] lvl_dn;
  logic             too_deep;
  logic [31:0]      cnt_wide;
  logic [15:0]      cnt_sat;

  // A document start clears the state before the token is handled
  assign ph     = doc_start ? PH_TOP : phase;
  assign err_e  = doc_start ? 1'b0 : err;
  assign lvl    = doc_start ? '0 : level;
  assign lvl_dn = lvl - LVL_W'(1);

  // The effective limit is the smaller of the register and the stack depth
  assign too_deep = (CMP_W'(lvl) >= CMP_W'(depth_limit)) || (lvl >= LVL_W'(MAX_DEPTH));

  assign cnt_wide = 32'(top_count);
  assign cnt_sat  = (|cnt_wide[31:16]) ? 16'hFFFF : cnt_wide[15:0];

  always_comb begin
    logic take;
    logic close;
    logic fail;
    logic complete;
    logic at_top;

    take     = 1'b0;
    close    = 1'b0;
    fail     = 1'b0;
    complete = 1'b0;
    at_top   = 1'b0;

    dec            = '0;
    dec.evt.depth  = 6'(lvl);
    dec.phase_next = ph;
    dec.err_next   = err_e;
    op             = '0;
    op.clear       = doc_start;

    // Decide what the token means in this phase
    if (!err_e && ph != PH_DONE) begin
      unique case (ph)
        PH_TOP, PH_VALUE: take = 1'b1;
        PH_ARR_ELEM: begin
          if (token_kind == TK_ARR_CLOSE) close = 1'b1;
          else take = 1'b1;
        end
        PH_OBJ_KEY: begin
          if (token_kind == TK_OBJ_CLOSE) begin
            close = 1'b1;
          end else if (token_kind == TK_STRING) begin
            dec.emit         = 1'b1;
            dec.evt.kind     = EV_KEY;
            dec.evt.text_ref = token_ref;
            dec.phase_next   = PH_COLON;
          end else begin
            fail = 1'b1;
          end
        end
        PH_COLON: begin
          if (token_kind == TK_COLON) dec.phase_next = PH_VALUE;
          else fail = 1'b1;
        end
        PH_AFTER: begin
          if (token_kind == TK_COMMA) begin
            dec.phase_next = top_obj ? PH_OBJ_KEY : PH_ARR_ELEM;
          end else if ((token_kind == TK_OBJ_CLOSE && top_obj) ||
                       (token_kind == TK_ARR_CLOSE && !top_obj)) begin
            close = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase
    end

    // Take a value: open a container or report a scalar; other kinds, or too deep a level, fail
    if (take) begin
      unique case (token_kind) inside
        TK_OBJ_OPEN, TK_ARR_OPEN: begin
          if (too_deep) begin
            fail = 1'b1;
          end else begin
            dec.emit       = 1'b1;
            dec.evt.kind   = (token_kind == TK_OBJ_OPEN) ? EV_OBJ_ENTER : EV_ARR_ENTER;
            op.push        = 1'b1;
            op.push_obj    = (token_kind == TK_OBJ_OPEN);
            dec.phase_next = (token_kind == TK_OBJ_OPEN) ? PH_OBJ_KEY : PH_ARR_ELEM;
          end
        end
        TK_STRING, TK_NUMBER, TK_BOOL, TK_NULL: begin
          if (too_deep) begin
            fail = 1'b1;
          end else begin
            dec.emit         = 1'b1;
            dec.evt.text_ref = token_ref;
            complete         = 1'b1;
            at_top           = (lvl == '0);
            case (token_kind)
              TK_STRING: dec.evt.kind = EV_STRING;
              TK_NUMBER: dec.evt.kind = EV_NUMBER;
              TK_BOOL: begin
                dec.evt.kind       = EV_BOOL;
                dec.evt.bool_value = bool_true;
              end
              default: dec.evt.kind = EV_NULL;
            endcase
          end
        end
        default: fail = 1'b1;
      endcase
    end

    // Close the top container and report its member count
    if (close) begin
      dec.emit      = 1'b1;
      dec.evt.kind  = top_obj ? EV_OBJ_LEAVE : EV_ARR_LEAVE;
      dec.evt.depth = 6'(lvl_dn);
      dec.evt.count = cnt_sat;
      op.pop        = 1'b1;
      complete      = 1'b1;
      at_top        = (lvl_dn == '0);
    end

    // A finished value ends the document or counts in its parent
    if (complete) begin
      if (at_top) begin
        dec.phase_next   = PH_DONE;
        dec.evt.done     = 1'b1;
      end else begin
        op.incr          = 1'b1;
        dec.phase_next   = PH_AFTER;
      end
    end

    // Grammar violation
    if (fail) begin
      dec            = '0;
      dec.emit       = 1'b1;
      dec.evt.kind   = EV_ERROR;
      dec.evt.depth  = 6'(lvl);
      dec.phase_next = ph;
      dec.err_next   = 1'b1;
      op             = '0;
      op.clear       = doc_start;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jtsp_checker.sv =====
`default_nettype none

`include "json_token_structure_parser_macros.svh"

module jtsp_checker import jtsp_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               evt_valid,
  input wire logic               evt_ready,
  input wire logic [3:0]         event_kind,
  input wire logic [5:0]         event_depth,
  input wire logic [15:0]        member_count,
  input wire logic [31:0]        text_ref,
  input wire logic               document_done,
  input wire logic               psel,
  input wire logic               penable,
  input wire logic               pwrite,
  input wire logic [PADDR_W-1:0] paddr,
  input wire logic [31:0]        pwdata,
  input wire logic [31:0]        prdata
);

  // A stalled event stays and keeps its kind, depth, count and text reference
  `JTSP_ASSERT_NEXT(a_evt_hold, !rst && evt_valid && !evt_ready, evt_valid && $stable(event_kind) && $stable(event_depth) && $stable(member_count) && $stable(text_ref), "event changed while stalled")

  // Only leave events carry a member count
  `JTSP_ASSERT_SAME(a_count_on_leave, evt_valid && event_kind != EV_OBJ_LEAVE && event_kind != EV_ARR_LEAVE, member_count == 16'd0, "member count outside a leave event")

  // An error never completes a document and carries no text
  `JTSP_ASSERT_SAME(a_error_clean, evt_valid && event_kind == EV_ERROR, !document_done && text_ref == 32'd0, "error event with payload")

  // A write to the limit reads back in the next cycle
  `JTSP_ASSERT_NEXT(a_limit_readback, !rst && psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_DEPTH_LIMIT, paddr[PADDR_W-1:2] != REG_DEPTH_LIMIT || prdata == {26'd0, $past(pwdata[5:0])}, "depth limit readback mismatch")

endmodule

bind json_token_structure_parser jtsp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .evt_valid     (evt.valid),
  .evt_ready     (evt.ready),
  .event_kind    (evt.event_kind),
  .event_depth   (evt.event_depth),
  .member_count  (evt.member_count),
  .text_ref      (evt.text_ref),
  .document_done (evt.document_done),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

`default_nettype wire

// ===== bench/json_token_structure_parser_test.sv =====
`timescale 1ns / 100ps

module json_token_structure_parser_test;
  import jtsp_pkg::*;

  localparam int          STACK_DEPTH   = MAX_DEPTH_DEF;
  localparam logic [15:0] COUNT_MAX     = 16'((64'd1 << COUNT_BITS_DEF) - 1);
  localparam int          SETTLE_CYCLES = 6;
  localparam logic [3:0]  TK_OTHER      = 4'd10;
  localparam logic [3:0]  TK_CODE_TOP   = 4'd15;
  localparam logic [PADDR_W-1:0] DEPTH_LIMIT_ADDR = {REG_DEPTH_LIMIT, 2'b00};
  localparam logic [3:0]  SCALAR_KINDS [4] = '{TK_STRING, TK_NUMBER, TK_BOOL, TK_NULL};

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  jtsp_token_if tok_if ();
  jtsp_event_if evt_if ();

  json_token_structure_parser u_dut (
    .clk     (clk),
    .rst     (rst),
    .tok     (tok_if),
    .evt     (evt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Parser state as predicted
  logic        nest_is_obj [STACK_DEPTH];
  logic [15:0] nest_count  [STACK_DEPTH];
  int unsigned nest_lvl;
  phase_t      grammar_phase;
  bit          doc_failed;
  logic [5:0]  depth_limit_cfg;

  event_t expected_events [$];
  event_t want_ev;

  int mismatches;
  int events_checked;
  int tokens_sent;
  int tokens_parsed;
  int send_idle_pct;
  int recv_stall_pct;
  int noise_permille;
  int hold_request;
  int hold_left;
  bit start_doc;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Grammar error: flag the document and report the current level
  function automatic bit raise_error(output event_t ev);
    ev = '0;
    ev.kind = EV_ERROR;
    ev.depth = 6'(nest_lvl);
    doc_failed = 1'b1;
    return 1'b1;
  endfunction

  // A value ended at the current level; returns 1 when the document is done
  function automatic logic finish_value();
    if (nest_lvl == 0) begin
      grammar_phase = PH_DONE;
      return 1'b1;
    end
    if (nest_count[nest_lvl-1] != COUNT_MAX) nest_count[nest_lvl-1]++;
    grammar_phase = PH_AFTER;
    return 1'b0;
  endfunction

  function automatic bit close_container(output event_t ev);
    logic        was_obj;
    logic [15:0] members;
    was_obj = nest_is_obj[nest_lvl-1];
    members = nest_count[nest_lvl-1];
    nest_lvl--;
    ev = '0;
    ev.kind = was_obj ? EV_OBJ_LEAVE : EV_ARR_LEAVE;
    ev.depth = 6'(nest_lvl);
    ev.count = members;
    ev.done = finish_value();
    return 1'b1;
  endfunction

  function automatic bit take_value(input logic [3:0] kind, input logic bt,
                                    input logic [31:0] tref, output event_t ev);
    int unsigned lim;
    lim = (depth_limit_cfg > STACK_DEPTH) ? STACK_DEPTH : depth_limit_cfg;
    ev = '0;
    if (kind == TK_OBJ_OPEN || kind == TK_ARR_OPEN) begin
      if (nest_lvl >= lim) return raise_error(ev);
      nest_is_obj[nest_lvl] = (kind == TK_OBJ_OPEN);
      nest_count[nest_lvl] = '0;
      ev.kind = (kind == TK_OBJ_OPEN) ? EV_OBJ_ENTER : EV_ARR_ENTER;
      ev.depth = 6'(nest_lvl);
      nest_lvl++;
      grammar_phase = (kind == TK_OBJ_OPEN) ? PH_OBJ_KEY : PH_ARR_ELEM;
      return 1'b1;
    end
    if (kind >= TK_STRING && kind <= TK_NULL) begin
      if (nest_lvl >= lim) return raise_error(ev);
      case (kind)
        TK_STRING: ev.kind = EV_STRING;
        TK_NUMBER: ev.kind = EV_NUMBER;
        TK_BOOL:   ev.kind = EV_BOOL;
        default:   ev.kind = EV_NULL;
      endcase
      ev.depth = 6'(nest_lvl);
      ev.bool_value = (kind == TK_BOOL) ? bt : 1'b0;
      ev.text_ref = tref;
      ev.done = finish_value();
      return 1'b1;
    end
    return raise_error(ev);
  endfunction

  // Advance the predicted parser by one token; returns 1 if it yields an event
  function automatic bit predict_token(input logic [3:0] kind, input logic bt,
                                       input logic [31:0] tref, input logic ds,
                                       output event_t ev);
    logic top_obj;
    ev = '0;
    if (ds) begin
      nest_lvl = 0;
      grammar_phase = PH_TOP;
      doc_failed = 1'b0;
    end
    if (doc_failed || grammar_phase == PH_DONE) return 1'b0;
    tokens_parsed++;
    top_obj = (nest_lvl > 0) ? nest_is_obj[nest_lvl-1] : 1'b0;
    case (grammar_phase)
      PH_TOP, PH_VALUE: return take_value(kind, bt, tref, ev);
      PH_ARR_ELEM: begin
        if (kind == TK_ARR_CLOSE) return close_container(ev);
        return take_value(kind, bt, tref, ev);
      end
      PH_OBJ_KEY: begin
        if (kind == TK_OBJ_CLOSE) return close_container(ev);
        if (kind == TK_STRING) begin
          grammar_phase = PH_COLON;
          ev.kind = EV_KEY;
          ev.depth = 6'(nest_lvl);
          ev.text_ref = tref;
          return 1'b1;
        end
        return raise_error(ev);
      end
      PH_COLON: begin
        if (kind == TK_COLON) begin
          grammar_phase = PH_VALUE;
          return 1'b0;
        end
        return raise_error(ev);
      end
      PH_AFTER: begin
        if (kind == TK_COMMA) begin
          grammar_phase = top_obj ? PH_OBJ_KEY : PH_ARR_ELEM;
          return 1'b0;
        end
        if ((kind == TK_OBJ_CLOSE && top_obj) || (kind == TK_ARR_CLOSE && !top_obj))
          return close_container(ev);
        return raise_error(ev);
      end
      default: return raise_error(ev);
    endcase
  endfunction

  // Offer one token, wait for the handshake, then predict its event
  task automatic send_token(input logic [3:0] kind, input logic bt,
                            input logic [31:0] tref, input logic ds);
    event_t ev;
    int     gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      tok_if.valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    tok_if.valid      <= 1'b1;
    tok_if.token_kind <= kind;
    tok_if.bool_true  <= bt;
    tok_if.token_ref  <= tref;
    tok_if.doc_start  <= ds;
    @(posedge clk);
    while (!tok_if.ready) @(posedge clk);
    tokens_sent++;
    if (predict_token(kind, bt, tref, ds, ev)) expected_events.push_back(ev);
  endtask

  // Random content token; opens a document if requested, may be corrupted
  task automatic put_token(input logic [3:0] kind);
    logic [3:0] k;
    logic       ds;
    k = kind;
    ds = start_doc;
    start_doc = 1'b0;
    if (noise_permille > 0) begin
      if ($urandom_range(999) < noise_permille) k = 4'($urandom_range(15));
      if ($urandom_range(999) < 5) ds = 1'b1;
    end
    send_token(k, 1'($urandom_range(1)), $urandom, ds);
  endtask

  // Stop offering and wait out every outstanding event
  task automatic drain_events;
    tok_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the depth limit over APB while idle
  task automatic set_depth_limit(input logic [5:0] value);
    drain_events();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DEPTH_LIMIT_ADDR;
    pwdata  <= {26'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    depth_limit_cfg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Open a chain of containers, optionally closing all of them again
  task automatic nest_chain(input int levels, input bit close_all);
    bit is_obj [64];
    int i;
    for (i = 0; i < levels; i++) begin
      if (i > 0 && is_obj[i-1]) begin
        put_token(TK_STRING);
        put_token(TK_COLON);
      end
      is_obj[i] = 1'($urandom_range(1));
      put_token(is_obj[i] ? TK_OBJ_OPEN : TK_ARR_OPEN);
    end
    if (close_all)
      for (i = levels - 1; i >= 0; i--) put_token(is_obj[i] ? TK_OBJ_CLOSE : TK_ARR_CLOSE);
  endtask

  // Emit one random value, now and then with a trailing comma; deep mode nests single members
  task automatic gen_value(input int budget, input bit deep);
    bit as_obj;
    int members;
    int i;
    if (budget <= 0 || $urandom_range(99) >= (deep ? 95 : 40)) begin
      put_token(SCALAR_KINDS[$urandom_range(3)]);
    end else begin
      as_obj = 1'($urandom_range(1));
      put_token(as_obj ? TK_OBJ_OPEN : TK_ARR_OPEN);
      members = deep ? 1 : $urandom_range(0, 4);
      for (i = 0; i < members; i++) begin
        if (i > 0) put_token(TK_COMMA);
        if (as_obj) begin
          put_token(TK_STRING);
          put_token(TK_COLON);
        end
        gen_value(budget - 1, deep);
      end
      if (members > 0 && $urandom_range(9) == 0) put_token(TK_COMMA);
      put_token(as_obj ? TK_OBJ_CLOSE : TK_ARR_CLOSE);
    end
  endtask

  task automatic run_random_docs(input int target);
    int base;
    bit deep;
    base = tokens_sent;
    while (tokens_sent - base < target) begin
      start_doc = 1'b1;
      deep = ($urandom_range(9) == 0);
      gen_value(deep ? 40 : $urandom_range(0, 4), deep);
      // trailing junk after the document is ignored
      if ($urandom_range(4) == 0) put_token(4'($urandom_range(15)));
    end
  endtask

  // Grammar corners: trailing comma, separators, errors, end of document
  task automatic test_directed;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_token(TK_OBJ_OPEN,  1'b0, 32'h0000_0000, 1'b1);
    send_token(TK_STRING,    1'b0, 32'hFFFF_FFFF, 1'b0);
    send_token(TK_COLON,     1'b0, 32'h1234_5678, 1'b0);
    send_token(TK_BOOL,      1'b1, 32'hA5A5_5A5A, 1'b0);
    send_token(TK_COMMA,     1'b1, 32'h0000_0001, 1'b0);
    send_token(TK_STRING,    1'b1, 32'h8000_0000, 1'b0);
    send_token(TK_COLON,     1'b0, 32'h0, 1'b0);
    send_token(TK_ARR_OPEN,  1'b0, 32'h0, 1'b0);
    send_token(TK_NUMBER,    1'b1, 32'hFFFF_FFFF, 1'b0);
    send_token(TK_COMMA,     1'b0, 32'h0, 1'b0);
    send_token(TK_BOOL,      1'b0, 32'h5A5A_A5A5, 1'b0);
    send_token(TK_ARR_CLOSE, 1'b0, 32'h0, 1'b0);
    send_token(TK_COMMA,     1'b0, 32'h0, 1'b0);
    send_token(TK_OBJ_CLOSE, 1'b0, 32'h0, 1'b0);
    send_token(TK_NULL,      1'b0, 32'hDEAD_BEEF, 1'b0);
    // wrong closer, then silence until the next document
    send_token(TK_ARR_OPEN,  1'b0, 32'h0, 1'b1);
    send_token(TK_OBJ_CLOSE, 1'b0, 32'h0, 1'b0);
    send_token(TK_COMMA,     1'b0, 32'h0, 1'b0);
    // non-string key
    send_token(TK_OBJ_OPEN,  1'b0, 32'h0, 1'b1);
    send_token(TK_NUMBER,    1'b0, 32'h7, 1'b0);
    // missing colon
    send_token(TK_OBJ_OPEN,  1'b0, 32'h0, 1'b1);
    send_token(TK_STRING,    1'b0, 32'h9, 1'b0);
    send_token(TK_STRING,    1'b0, 32'hA, 1'b0);
    // closer where a value is expected
    send_token(TK_OBJ_OPEN,  1'b0, 32'h0, 1'b1);
    send_token(TK_STRING,    1'b0, 32'hB, 1'b0);
    send_token(TK_COLON,     1'b0, 32'h0, 1'b0);
    send_token(TK_OBJ_CLOSE, 1'b0, 32'h0, 1'b0);
    // separators and unknown kinds at top level, then a bare scalar
    send_token(TK_COLON,     1'b0, 32'h0, 1'b1);
    send_token(TK_OTHER,     1'b0, 32'h0, 1'b1);
    send_token(TK_CODE_TOP,  1'b1, 32'hFFFF_FFFF, 1'b1);
    send_token(TK_STRING,    1'b0, 32'h0, 1'b1);
  endtask

  // Each limit: one container too deep, a full round trip at the limit if it is not zero, a scalar
  task automatic test_depth_limits;
    logic [5:0] limits [7];
    int         i;
    int         eff;
    limits = '{6'd1, 6'd0, 6'd2, 6'd40, 6'd63, 6'd32, 6'd5};
    for (i = 0; i < 7; i++) begin
      set_depth_limit(limits[i]);
      eff = (limits[i] > STACK_DEPTH) ? STACK_DEPTH : limits[i];
      start_doc = 1'b1;
      nest_chain(eff + 1, 1'b0);
      if (eff > 0) begin
        start_doc = 1'b1;
        nest_chain(eff, 1'b1);
      end
      start_doc = 1'b1;
      put_token(TK_NUMBER);
    end
  endtask

  // Hold the receiver for a long stretch while tokens keep coming
  task automatic test_backpressure;
    int i;
    set_depth_limit(6'd32);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 300;
    start_doc = 1'b1;
    put_token(TK_ARR_OPEN);
    for (i = 0; i < 40; i++) begin
      if (i > 0) put_token(TK_COMMA);
      put_token(TK_NUMBER);
    end
    put_token(TK_ARR_CLOSE);
    drain_events();
  endtask

  // Random documents with corruption under several limits and idle mixes
  task automatic test_random_docs;
    noise_permille = 20;
    set_depth_limit(6'd32);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_docs(100);
    set_depth_limit(6'd3);
    send_idle_pct = 57;
    recv_stall_pct = 0;
    run_random_docs(90);
    set_depth_limit(6'd32);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    run_random_docs(90);
    set_depth_limit(6'd63);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    run_random_docs(90);
    set_depth_limit(6'd1);
    run_random_docs(40);
    set_depth_limit(6'd2);
    send_idle_pct = 57;
    recv_stall_pct = 57;
    run_random_docs(40);
    noise_permille = 0;
  endtask

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      evt_if.ready <= 1'b0;
      hold_left--;
    end else begin
      evt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted event with the oldest prediction
  always @(posedge clk) begin
    if (!rst && evt_if.valid && evt_if.ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event kind=%0d depth=%0d count=%0d bool=%0d ref=%h done=%0d",
                 $time, evt_if.event_kind, evt_if.event_depth, evt_if.member_count,
                 evt_if.bool_value, evt_if.text_ref, evt_if.document_done);
        mismatches++;
      end else begin
        want_ev = expected_events.pop_front();
        events_checked++;
        if (evt_if.event_kind !== want_ev.kind || evt_if.event_depth !== want_ev.depth ||
            evt_if.member_count !== want_ev.count ||
            evt_if.bool_value !== want_ev.bool_value ||
            evt_if.text_ref !== want_ev.text_ref || evt_if.document_done !== want_ev.done) begin
          $display("%0t: expected kind=%0d depth=%0d count=%0d bool=%0d ref=%h done=%0d",
                   $time, want_ev.kind, want_ev.depth, want_ev.count, want_ev.bool_value,
                   want_ev.text_ref, want_ev.done);
          $display("%0t:   actual kind=%0d depth=%0d count=%0d bool=%0d ref=%h done=%0d",
                   $time, evt_if.event_kind, evt_if.event_depth, evt_if.member_count,
                   evt_if.bool_value, evt_if.text_ref, evt_if.document_done);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tok_if.valid = 1'b0;
    tok_if.token_kind = TK_OBJ_OPEN;
    tok_if.bool_true = 1'b0;
    tok_if.token_ref = '0;
    tok_if.doc_start = 1'b0;
    evt_if.ready = 1'b0;
    mismatches = 0;
    events_checked = 0;
    tokens_sent = 0;
    tokens_parsed = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    noise_permille = 0;
    hold_request = 0;
    hold_left = 0;
    start_doc = 1'b0;
    nest_lvl = 0;
    grammar_phase = PH_TOP;
    doc_failed = 1'b0;
    depth_limit_cfg = DEPTH_LIMIT_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_depth_limits();
    test_backpressure();
    test_random_docs();
    drain_events();

    $display("Run covered %0d tokens (%0d parsed) and %0d checked events,", tokens_sent,
             tokens_parsed, events_checked);
    $display("depth limits 0 to 63, grammar errors, a long hold-off and idle mixes.");
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/jtsp_pkg.sv
rtl/jtsp_token_if.sv
rtl/jtsp_event_if.sv
rtl/jtsp_apb_regs.sv
rtl/jtsp_stack.sv
rtl/jtsp_grammar.sv
rtl/json_token_structure_parser.sv
rtl/jtsp_checker.sv
bench/json_token_structure_parser_test.sv
